>>> rtl/cmac_pkg.sv
// ----------------------------------------------------------------------------
// cmac_pkg
// Shared types, constants and AES round functions for the CMAC engine.
// ----------------------------------------------------------------------------
package cmac_pkg;

  localparam int unsigned BlkBytes = 16;
  localparam int unsigned CntW     = 5;
  localparam int unsigned IdxW     = 8;

  localparam logic [IdxW-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [IdxW-1:0] REG_KEY_LOW  = 8'd1;

  localparam logic [7:0]   PAD_BYTE  = 8'h80;
  localparam logic [127:0] DBL_POLY  = 128'h87;
  localparam logic [3:0]   LAST_RND  = 4'd10;

  typedef enum logic [1:0] {
    CMD_MID,
    CMD_FULL,
    CMD_PAD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e    kind;
    logic [127:0] blk;
  } cmd_t;

  typedef struct packed {
    logic rekey_pending;
    logic busy;
  } bk_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte 0 of a block sits in the top eight bits.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    int unsigned  r, c, src;
    t = '0;
    for (c = 0; c < 4; c++) begin
      for (r = 0; r < 4; r++) begin
        src = r + 4 * ((c + r) % 4);
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] t);
    logic [127:0] m;
    logic [7:0]   a0, a1, a2, a3, all;
    int unsigned  c;
    m = '0;
    for (c = 0; c < 4; c++) begin
      a0  = t[127 - 32 * c -: 8];
      a1  = t[119 - 32 * c -: 8];
      a2  = t[111 - 32 * c -: 8];
      a3  = t[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      m[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      m[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      m[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      m[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return m;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] tw, w0, w1, w2, w3;
    tw = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ tw;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] dbl(input logic [127:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? DBL_POLY : 128'h0);
  endfunction

endpackage

>>> rtl/cmac_ifs.sv
// ----------------------------------------------------------------------------
// cmac channel interfaces
// Byte input, tag output and key write channels of the CMAC engine.
// ----------------------------------------------------------------------------
interface cmac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface cmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] mac_high;
  logic [63:0] mac_low;
  modport source (output valid, mac_high, mac_low, input ready);
  modport sink   (input valid, mac_high, mac_low, output ready);
endinterface

interface cmac_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/aes_cmac_engine.sv
// ----------------------------------------------------------------------------
// aes_cmac_engine
// AES-128 CMAC over a byte stream; tag given on out_o after the beat that ends a message.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   data_byte[7:0], byte_present, last_byte
//  out_o    out  valid/ready   mac_high[63:0], mac_low[63:0]
//  cfg_i    in   valid/ready   index[7:0] (0 key_high, 1 key_low), data[63:0]
//
//  One byte beat per cycle while the command queue has room and no second command
//  is pending. Each block goes through the iterative AES core as load, ten rounds
//  and retire; 16 byte beats fill it. A two-entry command queue sits between
//  byte gathering and the AES core. After reset and after each key write the core
//  derives K1/K2; bytes keep queuing meanwhile. A last byte beat that follows a
//  full block stalls in_i while its padded last command is issued.
// ----------------------------------------------------------------------------
module aes_cmac_engine
  import cmac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cmac_in_if.sink    in_i,
  cmac_out_if.source out_o,
  cmac_cfg_if.sink   cfg_i
);

  cmd_t       f_cmd, q_cmd;
  logic       f_valid, f_ready, q_valid, q_ready;
  bk_status_t bk_stat;

  cmac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (f_cmd),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready)
  );

  cmac_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_cmd),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  cmac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .out_o       (out_o),
    .status_o    (bk_stat)
  );

  a_rekey_after_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready &&
     (cfg_i.index == REG_KEY_HIGH || cfg_i.index == REG_KEY_LOW))
    |=> bk_stat.rekey_pending)
    else $error("key write did not schedule subkey derivation");

  a_no_pop_while_rekey : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.rekey_pending |-> !(q_valid && q_ready))
    else $error("block taken before subkeys derived");

  a_no_pop_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.busy |-> !q_ready)
    else $error("block taken while AES core busy");

  a_in_needs_space : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> f_ready)
    else $error("byte beat accepted without queue space");

endmodule

>>> rtl/cmac_front.sv
// ----------------------------------------------------------------------------
// cmac_front
// Gathers bytes into blocks and issues mid, full-last and padded-last commands.
// ----------------------------------------------------------------------------
module cmac_front
  import cmac_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  cmac_in_if.sink      in_i,
  output cmd_t         cmd_o,
  output logic         cmd_valid_o,
  input  logic         cmd_ready_i
);

  logic [127:0]    buf_q, buf_d, nb;
  logic [CntW-1:0] cnt_q, cnt_d, ncnt;
  logic            pend_q, pend_d;
  logic            full_blk, acc;
  logic [3:0]      wr_pos;

  function automatic cmd_t last_cmd(input logic [127:0] b, input logic [CntW-1:0] c);
    cmd_t        r;
    int unsigned k;
    r.kind = (c == CntW'(BlkBytes)) ? CMD_FULL : CMD_PAD;
    r.blk  = b;
    if (c != CntW'(BlkBytes)) begin
      for (k = 0; k < BlkBytes; k++) begin
        if (CntW'(k) == c) begin
          r.blk[127 - 8 * k -: 8] = PAD_BYTE;
        end else if (CntW'(k) > c) begin
          r.blk[127 - 8 * k -: 8] = 8'h00;
        end
      end
    end
    return r;
  endfunction

  assign full_blk   = (cnt_q == CntW'(BlkBytes));
  assign in_i.ready = !pend_q && cmd_ready_i;
  assign acc        = in_i.valid && in_i.ready;
  assign wr_pos     = full_blk ? 4'd0 : cnt_q[3:0];
  assign ncnt       = full_blk ? CntW'(1) : cnt_q + CntW'(1);

  always_comb begin
    nb = buf_q;
    for (int unsigned k = 0; k < BlkBytes; k++) begin
      if (4'(k) == wr_pos) begin
        nb[127 - 8 * k -: 8] = in_i.data_byte;
      end
    end
  end

  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o       = '{kind: CMD_MID, blk: buf_q};
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    if (pend_q) begin
      // second command of a beat that followed a full block and ended the message
      cmd_valid_o = 1'b1;
      cmd_o       = last_cmd(buf_q, cnt_q);
      if (cmd_ready_i) begin
        pend_d = 1'b0;
        cnt_d  = '0;
      end
    end else if (acc) begin
      if (in_i.byte_present) begin
        buf_d = nb;
        cnt_d = ncnt;
      end
      if (in_i.byte_present && full_blk) begin
        cmd_valid_o = 1'b1;
        pend_d      = in_i.last_byte;
      end else if (in_i.last_byte) begin
        cmd_valid_o = 1'b1;
        cmd_o       = in_i.byte_present ? last_cmd(nb, ncnt) : last_cmd(buf_q, cnt_q);
        cnt_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

>>> rtl/cmac_queue.sv
// ----------------------------------------------------------------------------
// cmac_queue
// Two-entry command queue between the byte front and the AES back.
// ----------------------------------------------------------------------------
module cmac_queue
  import cmac_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cmd_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/cmac_back.sv
// ----------------------------------------------------------------------------
// cmac_back
// Iterative AES-128 with on-the-fly key schedule, CBC chain and subkeys.
// ----------------------------------------------------------------------------
module cmac_back
  import cmac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cmac_cfg_if.sink   cfg_i,
  input  cmd_t       cmd_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  cmac_out_if.source out_o,
  output bk_status_t status_o
);

  logic [127:0] key_q, k1_q, k2_q, chain_q, st_q, rk_q, tag_q;
  logic [127:0] rk_nx, st_nx, mask, sh;
  logic [3:0]   rnd_q;
  logic         busy_q, done_q, derive_q, rekey_q, oval_q;
  cmd_kind_e    kind_q;
  logic         cfg_hit, start_derive, start_cmd, step, finish, out_free, fin_last;

  assign cfg_i.ready  = 1'b1;
  assign cfg_hit      = cfg_i.valid &&
                        (cfg_i.index == REG_KEY_HIGH || cfg_i.index == REG_KEY_LOW);
  assign cmd_ready_o  = !busy_q && !rekey_q && !cfg_hit;
  assign start_derive = !busy_q && rekey_q && !cfg_hit;
  assign start_cmd    = cmd_valid_i && cmd_ready_o;
  assign step         = busy_q && !done_q && !cfg_hit;
  assign out_free     = !oval_q || out_o.ready;
  assign finish       = busy_q && done_q && !cfg_hit &&
                        (derive_q || kind_q == CMD_MID || out_free);
  assign fin_last     = finish && !derive_q && kind_q != CMD_MID;

  assign rk_nx = key_next(rk_q, RCON[rnd_q]);
  assign sh    = sub_shift(st_q);
  assign st_nx = ((rnd_q == LAST_RND) ? sh : mix_cols(sh)) ^ rk_nx;

  always_comb begin
    case (cmd_i.kind)
      CMD_MID:  mask = '0;
      CMD_FULL: mask = k1_q;
      CMD_PAD:  mask = k2_q;
      default:  mask = '0;
    endcase
  end

  assign out_o.valid    = oval_q;
  assign out_o.mac_high = tag_q[127:64];
  assign out_o.mac_low  = tag_q[63:0];
  assign status_o       = '{rekey_pending: rekey_q, busy: busy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      chain_q  <= '0;
      rekey_q  <= 1'b1;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      derive_q <= 1'b0;
      kind_q   <= CMD_MID;
      rnd_q    <= 4'd1;
      oval_q   <= 1'b0;
    end else begin
      if (cfg_hit) begin
        // abort any subkey or block run and derive again from the new key
        if (cfg_i.index == REG_KEY_HIGH) key_q[127:64] <= cfg_i.data;
        else                            key_q[63:0]   <= cfg_i.data;
        rekey_q <= 1'b1;
        busy_q  <= 1'b0;
      end
      if (start_derive || start_cmd) begin
        busy_q   <= 1'b1;
        done_q   <= 1'b0;
        rnd_q    <= 4'd1;
        derive_q <= start_derive;
        rekey_q  <= 1'b0;
        kind_q   <= cmd_i.kind;
      end
      if (step) begin
        rnd_q <= rnd_q + 4'd1;
        if (rnd_q == LAST_RND) done_q <= 1'b1;
      end
      if (finish) begin
        busy_q <= 1'b0;
        if (!derive_q) chain_q <= (kind_q == CMD_MID) ? st_q : '0;
      end
      if (fin_last)                        oval_q <= 1'b1;
      else if (oval_q && out_o.ready)      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_derive) begin
      st_q <= key_q;
      rk_q <= key_q;
    end else if (start_cmd) begin
      st_q <= chain_q ^ cmd_i.blk ^ mask ^ key_q;
      rk_q <= key_q;
    end else if (step) begin
      st_q <= st_nx;
      rk_q <= rk_nx;
    end
    if (finish && derive_q) begin
      k1_q <= dbl(st_q);
      k2_q <= dbl(dbl(st_q));
    end
    if (fin_last) tag_q <= st_q;
  end

endmodule

>>> tb/tb_aes_cmac_engine.sv
// ----------------------------------------------------------------------------
// tb_aes_cmac_engine
// Self-checking bench for the AES-128 CMAC engine. Byte beats are queued by a
// stimulus block, driven in random bursts, and each tag is checked against a
// behavioral CMAC computed alongside. Keys change only between messages.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_aes_cmac_engine;
  import cmac_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic [63:0] mac_high;
    logic [63:0] mac_low;
  } tag_t;

  localparam int unsigned MaxCycles = 400000;

  logic clk_i;
  logic rst_ni;

  cmac_in_if  in_if ();
  cmac_out_if out_if ();
  cmac_cfg_if cfg_if ();

  aes_cmac_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  beat_t        beat_q[$];
  tag_t         tag_q[$];
  int unsigned  err_cnt;
  int unsigned  cyc_cnt;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  hold_left;
  int unsigned  stall_phase;
  logic         hold_req;

  // behavioral CMAC state
  logic [127:0] key_m;
  logic [127:0] k1_m, k2_m;
  logic [127:0] chain_m;
  logic [127:0] blk_m;
  int unsigned  held_m;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] gf2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_enc(input logic [127:0] k, input logic [127:0] p);
    logic [127:0] s, t, rk;
    logic [31:0]  tw;
    logic [7:0]   a0, a1, a2, a3, x;
    int           rnd, r, c;
    rk = k;
    s = p ^ rk;
    for (rnd = 1; rnd <= 10; rnd++) begin
      for (c = 0; c < 4; c++)
        for (r = 0; r < 4; r++)
          t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      if (rnd < 10) begin
        for (c = 0; c < 4; c++) begin
          a0 = t[127 - 32 * c -: 8];
          a1 = t[119 - 32 * c -: 8];
          a2 = t[111 - 32 * c -: 8];
          a3 = t[103 - 32 * c -: 8];
          x  = a0 ^ a1 ^ a2 ^ a3;
          t[127 - 32 * c -: 8] = a0 ^ x ^ gf2(a0 ^ a1);
          t[119 - 32 * c -: 8] = a1 ^ x ^ gf2(a1 ^ a2);
          t[111 - 32 * c -: 8] = a2 ^ x ^ gf2(a2 ^ a3);
          t[103 - 32 * c -: 8] = a3 ^ x ^ gf2(a3 ^ a0);
        end
      end
      tw = {SBOX[rk[23:16]] ^ RCON[rnd], SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      rk[127:96] = rk[127:96] ^ tw;
      rk[95:64]  = rk[95:64] ^ rk[127:96];
      rk[63:32]  = rk[63:32] ^ rk[95:64];
      rk[31:0]   = rk[31:0] ^ rk[63:32];
      s = t ^ rk;
    end
    return s;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  task automatic derive_subkeys();
    k1_m = gf_double(aes_enc(key_m, 128'h0));
    k2_m = gf_double(k1_m);
  endtask

  // Advance the model by one beat; push a tag when the message ends.
  task automatic cmac_step(input beat_t b);
    logic [127:0] blk;
    tag_t         tg;
    if (b.byte_present) begin
      if (held_m >= 16) begin
        chain_m = aes_enc(key_m, chain_m ^ blk_m);
        held_m = 0;
      end
      blk_m[127 - 8 * held_m -: 8] = b.data_byte;
      held_m++;
    end
    if (b.last_byte) begin
      if (held_m >= 16) begin
        chain_m = aes_enc(key_m, chain_m ^ blk_m ^ k1_m);
      end else begin
        blk = '0;
        for (int i = 0; i < 16; i++)
          if (i < held_m) blk[127 - 8 * i -: 8] = blk_m[127 - 8 * i -: 8];
          else if (i == held_m) blk[127 - 8 * i -: 8] = PAD_BYTE;
        chain_m = aes_enc(key_m, chain_m ^ blk ^ k2_m);
      end
      tg.mac_high = chain_m[127:64];
      tg.mac_low  = chain_m[63:0];
      tag_q.push_back(tg);
      chain_m = '0;
      held_m = 0;
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, exp, cyc_cnt);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
      in_if.byte_present <= 1'b0;
      in_if.last_byte <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      automatic logic busy = in_if.valid && !in_if.ready;
      if (in_if.valid && in_if.ready) begin
        cmac_step(beat_q.pop_front());
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          in_if.valid <= 1'b1;
          {in_if.data_byte, in_if.byte_present, in_if.last_byte} <= beat_q[0];
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and sink stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_phase <= 0;
      hold_left <= 0;
      cyc_cnt <= 0;
    end else begin
      tag_t ex;
      cyc_cnt <= cyc_cnt + 1;
      if (out_if.valid && out_if.ready) begin
        if (tag_q.size() == 0) begin
          report("unexpected tag", out_if.mac_high, 64'h0);
        end else begin
          ex = tag_q.pop_front();
          if (out_if.mac_high !== ex.mac_high) report("mac_high", out_if.mac_high, ex.mac_high);
          if (out_if.mac_low !== ex.mac_low) report("mac_low", out_if.mac_low, ex.mac_low);
        end
      end
      stall_phase <= (stall_phase + 1) % 23;
      if (hold_req && hold_left == 0) hold_left <= 600;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (stall_phase < 9) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(2) != 0);
      end
      if (cyc_cnt >= MaxCycles) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic put_beat(input logic [7:0] d, input logic p, input logic l);
    beat_t b;
    b.data_byte = d;
    b.byte_present = p;
    b.last_byte = l;
    beat_q.push_back(b);
  endtask

  task automatic put_msg(input int unsigned len, input logic with_idle);
    for (int unsigned i = 0; i < len; i++) begin
      if (with_idle && $urandom_range(7) == 0) put_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      put_beat(8'($urandom_range(255)), 1'b1, (i == len - 1));
    end
    if (len == 0) put_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Drain the queue and the engine before touching the key.
  task automatic wait_idle();
    while (beat_q.size() != 0 || tag_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [IdxW-1:0] idx, input logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == REG_KEY_HIGH) key_m[127:64] = val;
    else if (idx == REG_KEY_LOW) key_m[63:0] = val;
    derive_subkeys();
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    err_cnt = 0;
    hold_req = 1'b0;
    key_m = '0;
    chain_m = '0;
    blk_m = '0;
    held_m = 0;
    derive_subkeys();
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-zero key, then the standard test key, then an all-ones key
    put_msg(0, 1'b0);
    put_beat(8'h00, 1'b1, 1'b1);
    wait_idle();
    write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
    write_key(8'd7, 64'hdeadbeefdeadbeef);
    put_msg(0, 1'b0);
    for (int i = 0; i < 16; i++) put_beat((i == 0) ? 8'hff : 8'h00, 1'b1, (i == 15));
    put_beat(8'h55, 1'b0, 1'b0);
    put_beat(8'haa, 1'b1, 1'b0);
    put_beat(8'h00, 1'b0, 1'b1);
    wait_idle();
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    put_msg(17, 1'b0);
    put_msg(15, 1'b0);
    wait_idle();

    // random messages under several keys, one long sink hold-off
    n = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_key(REG_KEY_HIGH, (ph == 5) ? 64'h0 : {$urandom, $urandom});
      write_key(REG_KEY_LOW, (ph == 5) ? 64'h0 : {$urandom, $urandom});
      if (ph == 2) hold_req = 1'b1;
      for (int m = 0; m < 7; m++) begin
        case ($urandom_range(4))
          0: put_msg(0, 1'b0);
          1: put_msg(16 * $urandom_range(2, 1), 1'b1);
          default: put_msg($urandom_range(33, 1), 1'b1);
        endcase
      end
      // keep the request up across a full edge so the sink sees it
      repeat (2) @(posedge clk_i);
      hold_req = 1'b0;
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cmac_pkg.sv
rtl/cmac_ifs.sv
rtl/cmac_front.sv
rtl/cmac_queue.sv
rtl/cmac_back.sv
rtl/aes_cmac_engine.sv
tb/tb_aes_cmac_engine.sv
